/* sv/pv2h_pkg.sv */
// Shared types and constants for the PROXY v2 header builder.
// No dependencies; every other file in this block imports it.
package pv2h_pkg;

    // Request record, one per accepted input item.
    typedef struct packed {
        logic [1:0]  header_mode;
        logic [3:0]  src_family;
        logic [3:0]  dst_family;
        logic [63:0] src_addr_hi;
        logic [63:0] src_addr_lo;
        logic [63:0] dst_addr_hi;
        logic [63:0] dst_addr_lo;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] out_capacity;
    } t_hdr_in;

    // One output item: a header byte or a single status item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       final_byte;
        logic [1:0] status;
        logic [5:0] header_length;
    } t_hdr_out;

    typedef enum logic [1:0] {
        K_HDR,
        K_OFF,
        K_ERR
    } t_kind;

    // Classified command passed from front to back. Addresses are left
    // aligned: an IPv4 address sits in bits 127:96.
    typedef struct packed {
        t_kind        kind;
        logic         is_v4;
        logic [127:0] src_addr;
        logic [127:0] dst_addr;
        logic [15:0]  src_port;
        logic [15:0]  dst_port;
    } t_cmd;

    typedef enum logic {
        S_IDLE,
        S_SEND
    } t_state;

    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_V2  = 2'd2;

    localparam logic [3:0] FAM_V4 = 4'd4;
    localparam logic [3:0] FAM_V6 = 4'd6;

    localparam logic [1:0] STS_OK  = 2'd0;
    localparam logic [1:0] STS_OFF = 2'd1;
    localparam logic [1:0] STS_ERR = 2'd2;

    localparam logic [5:0] LEN_V4 = 6'd28;
    localparam logic [5:0] LEN_V6 = 6'd52;

    localparam logic [15:0] PLEN_V4 = 16'd12;
    localparam logic [15:0] PLEN_V6 = 16'd36;

    localparam logic [7:0] VER_CMD  = 8'h21;
    localparam logic [7:0] FAM_TCP4 = 8'h11;
    localparam logic [7:0] FAM_TCP6 = 8'h21;

    localparam logic [95:0] SIGNATURE = 96'h0D0A_0D0A_000D_0A51_5549_540A;

    localparam int HDR_BITS = 52 * 8;

    // Default depth of the command queue between front and back.
    localparam int QDEPTH_DEF = 2;

endpackage

/* sv/pv2h_front.sv */
// Front end: classifies one request into a header, mode-off or error command.
// Depends on pv2h_pkg.
module pv2h_front (
    input  pv2h_pkg::t_hdr_in i_hdr,
    output pv2h_pkg::t_cmd    o_cmd
);
    import pv2h_pkg::*;

    logic        w_src_mapped;
    logic        w_dst_mapped;
    logic        w_conv;
    logic [3:0]  w_sfam;
    logic [3:0]  w_dfam;
    logic        w_fam_bad;
    logic [15:0] w_need;

    // ::ffff:a.b.c.d check
    assign w_src_mapped = (i_hdr.src_addr_hi == 64'd0) &&
                          (i_hdr.src_addr_lo[63:32] == 32'h0000_FFFF);
    assign w_dst_mapped = (i_hdr.dst_addr_hi == 64'd0) &&
                          (i_hdr.dst_addr_lo[63:32] == 32'h0000_FFFF);
    assign w_conv = (i_hdr.src_family == FAM_V6) && (i_hdr.dst_family == FAM_V6) &&
                    w_src_mapped && w_dst_mapped;

    assign w_sfam = w_conv ? FAM_V4 : i_hdr.src_family;
    assign w_dfam = w_conv ? FAM_V4 : i_hdr.dst_family;
    assign w_fam_bad = (w_sfam != w_dfam) || ((w_sfam != FAM_V4) && (w_sfam != FAM_V6));
    assign w_need = (w_sfam == FAM_V4) ? {10'd0, LEN_V4} : {10'd0, LEN_V6};

    always_comb begin
        o_cmd.is_v4    = (w_sfam == FAM_V4);
        o_cmd.src_port = i_hdr.src_port;
        o_cmd.dst_port = i_hdr.dst_port;
        if (w_conv) begin
            o_cmd.src_addr = {i_hdr.src_addr_lo[31:0], 96'd0};
            o_cmd.dst_addr = {i_hdr.dst_addr_lo[31:0], 96'd0};
        end else begin
            o_cmd.src_addr = {i_hdr.src_addr_hi, i_hdr.src_addr_lo};
            o_cmd.dst_addr = {i_hdr.dst_addr_hi, i_hdr.dst_addr_lo};
        end

        if (i_hdr.header_mode == MODE_OFF) begin
            o_cmd.kind = K_OFF;
        end else if (i_hdr.header_mode != MODE_V2) begin
            o_cmd.kind = K_ERR;
        end else if (w_fam_bad || (i_hdr.out_capacity < w_need)) begin
            o_cmd.kind = K_ERR;
        end else begin
            o_cmd.kind = K_HDR;
        end
    end

endmodule

/* sv/pv2h_queue.sv */
// Small command FIFO decoupling the classifier from the serializer.
// Depends on pv2h_pkg. DEPTH must be a power of two, 2 or more.
module pv2h_queue #(
    parameter int DEPTH = pv2h_pkg::QDEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  pv2h_pkg::t_cmd  i_wdata,
    output logic            o_full,
    input  logic            i_rd,
    output pv2h_pkg::t_cmd  o_rdata,
    output logic            o_empty
);
    import pv2h_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wptr;
    logic [AW-1:0]   r_rptr;
    logic [AW:0]     r_cnt;
    logic [AW-1:0]   n_wptr;
    logic [AW-1:0]   n_rptr;
    logic [AW:0]     n_cnt;
    logic            w_wr;
    logic            w_rd;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_comb begin
        n_wptr = w_wr ? r_wptr + 1'b1 : r_wptr;
        n_rptr = w_rd ? r_rptr + 1'b1 : r_rptr;
        n_cnt  = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

/* sv/pv2h_back.sv */
// Back end: turns queued commands into output items, one byte per cycle while the
// consumer pops, through a single output register. Depends on pv2h_pkg.
module pv2h_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pv2h_pkg::t_cmd     i_cmd,
    input  logic               i_q_empty,
    output logic               o_q_rd,
    input  logic               i_pop,
    output logic               o_empty,
    output pv2h_pkg::t_hdr_out o_res
);
    import pv2h_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [HDR_BITS-1:0]   r_shift;
    logic [HDR_BITS-1:0]   n_shift;
    logic [5:0]            r_rem;
    logic [5:0]            n_rem;
    logic [5:0]            r_len;
    logic [5:0]            n_len;
    t_hdr_out              r_out;
    t_hdr_out              n_out;
    logic                  r_out_vld;
    logic                  n_out_vld;
    logic                  w_adv;

    // Full header image, byte 0 in the top bits; IPv4 leaves the tail unused.
    function automatic logic [HDR_BITS-1:0] build_hdr(input t_cmd c);
        logic [HDR_BITS-1:0] h;
        if (c.is_v4) begin
            h = {SIGNATURE, VER_CMD, FAM_TCP4, PLEN_V4,
                 c.src_addr[127:96], c.dst_addr[127:96],
                 c.src_port, c.dst_port, 192'd0};
        end else begin
            h = {SIGNATURE, VER_CMD, FAM_TCP6, PLEN_V6,
                 c.src_addr, c.dst_addr, c.src_port, c.dst_port};
        end
        return h;
    endfunction

    assign o_empty = !r_out_vld;
    assign o_res   = r_out;
    // output slot free this cycle
    assign w_adv   = !r_out_vld || i_pop;

    always_comb begin
        n_state   = r_state;
        n_shift   = r_shift;
        n_rem     = r_rem;
        n_len     = r_len;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_pop;
        o_q_rd    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty && w_adv) begin
                    o_q_rd = 1'b1;
                    if (i_cmd.kind == K_HDR) begin
                        n_shift = build_hdr(i_cmd);
                        n_len   = i_cmd.is_v4 ? LEN_V4 : LEN_V6;
                        n_rem   = i_cmd.is_v4 ? LEN_V4 : LEN_V6;
                        n_state = S_SEND;
                    end else begin
                        n_out.data_byte     = 8'd0;
                        n_out.byte_valid    = 1'b0;
                        n_out.final_byte    = 1'b1;
                        n_out.status        = (i_cmd.kind == K_OFF) ? STS_OFF : STS_ERR;
                        n_out.header_length = 6'd0;
                        n_out_vld           = 1'b1;
                    end
                end
            end
            S_SEND: begin
                if (w_adv) begin
                    n_out.data_byte     = r_shift[HDR_BITS-1 -: 8];
                    n_out.byte_valid    = 1'b1;
                    n_out.final_byte    = (r_rem == 6'd1);
                    n_out.status        = STS_OK;
                    n_out.header_length = r_len;
                    n_out_vld           = 1'b1;
                    n_shift             = {r_shift[HDR_BITS-9:0], 8'h00};
                    n_rem               = r_rem - 6'd1;
                    if (r_rem == 6'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_len   <= n_len;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rem     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rem     <= n_rem;
            r_out_vld <= n_out_vld;
        end
    end

    a_send_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND) |-> (r_rem != 6'd0))
        else $error("serializer running with no bytes left");

    a_status_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.byte_valid) |-> (r_out.final_byte && r_out.status != STS_OK))
        else $error("status item must be final and carry a non-ok status");

    a_last_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SEND) && w_adv && (r_rem == 6'd1)) |=>
        (r_out.final_byte && r_out_vld && (r_state == S_IDLE)))
        else $error("last header byte not flagged final");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND) |-> !o_q_rd)
        else $error("command fetched while a header is still streaming");

endmodule

/* sv/proxy_v2_header_builder.sv */
// Top level of the PROXY v2 header builder: front classifier, command
// queue and byte serializer. Depends on pv2h_pkg, pv2h_front, pv2h_queue, pv2h_back.

// Each request pushed in becomes either a stream of header bytes (28 for
// TCP over IPv4, 52 for TCP over IPv6, final_byte set on the last one) or
// a single status item (mode off, or an error for text v1 mode, an unknown
// mode, bad or mismatched address families, or a capacity below the header
// length). Both IPv4-mapped IPv6 endpoints are sent as IPv4. Requests are
// classified on entry and queued (QUEUE_DEPTH deep, a power of two), so
// push stays open while a header streams out. The serializer owns the
// rate: a header first loads the byte shifter and then shifts out its
// bytes as the consumer pops them; a status item goes straight to the
// output register, which sits on the result side, so a stalled consumer
// holds the current item while the queue fills.
module proxy_v2_header_builder #(
    parameter int QUEUE_DEPTH = pv2h_pkg::QDEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  pv2h_pkg::t_hdr_in  i_hdr,
    output logic               empty,
    input  logic               pop,
    output pv2h_pkg::t_hdr_out o_res
);
    import pv2h_pkg::*;

    t_cmd w_cmd_in;
    t_cmd w_cmd_out;
    logic w_q_full;
    logic w_q_empty;
    logic w_q_rd;

    // classify the request as it arrives
    pv2h_front u_front (
        .i_hdr (i_hdr),
        .o_cmd (w_cmd_in)
    );

    // decoupling queue: front writes on accept, back reads when it starts
    pv2h_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (w_cmd_in),
        .o_full  (w_q_full),
        .i_rd    (w_q_rd),
        .o_rdata (w_cmd_out),
        .o_empty (w_q_empty)
    );

    assign full = w_q_full;

    // byte serializer and output register
    pv2h_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd_out),
        .i_q_empty (w_q_empty),
        .o_q_rd    (w_q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (o_res)
    );

endmodule
